// File: hdl/ftppcp_pkg.sv
package ftppcp_pkg;

    localparam int DEF_MAX_PAYLOAD = 2048;
    localparam int POS_OUT_W       = 11;

    localparam logic [3:0] PH_HUNT = 4'd0;
    localparam logic [3:0] PH_KW1  = 4'd1;
    localparam logic [3:0] PH_KW2  = 4'd2;
    localparam logic [3:0] PH_KW3  = 4'd3;
    localparam logic [3:0] PH_KW4  = 4'd4;
    localparam logic [3:0] PH_NUM0 = 4'd5;
    localparam logic [3:0] PH_NUM1 = 4'd6;
    localparam logic [3:0] PH_NUM2 = 4'd7;
    localparam logic [3:0] PH_NUM3 = 4'd8;
    localparam logic [3:0] PH_NUM4 = 4'd9;
    localparam logic [3:0] PH_NUM5 = 4'd10;

    localparam logic [7:0] CH_P_UP = 8'h50;
    localparam logic [7:0] CH_P_LO = 8'h70;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_SPACE = 8'h20;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       may_start;
        logic       last;
    } t_in_word;

    typedef struct packed {
        logic [31:0]          client_addr;
        logic [15:0]          client_port;
        logic [POS_OUT_W-1:0] arg_offset;
        logic [POS_OUT_W-1:0] arg_length;
    } t_out_word;

    typedef struct packed {
        logic hit;
        logic found;
    } t_scan_stat;

    // expected keyword byte once ph bytes have matched
    function automatic logic [7:0] kw_char(input logic [3:0] ph, input logic up);
        logic [7:0] c;
        case (ph)
            PH_KW1:  c = 8'h6F;
            PH_KW2:  c = 8'h72;
            PH_KW3:  c = 8'h74;
            PH_KW4:  c = CH_SPACE;
            default: c = CH_SPACE;
        endcase
        if (up && ph != PH_KW4) begin
            c = c - CH_SPACE;
        end
        return c;
    endfunction

endpackage

// File: hdl/ftppcp_scan.sv
module ftppcp_scan
    import ftppcp_pkg::*;
#(
    parameter int MAX_PAYLOAD = DEF_MAX_PAYLOAD
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  t_in_word   i_word,
    output t_out_word  o_res,
    output t_scan_stat o_stat
);

    localparam int PW = $clog2(MAX_PAYLOAD);
    localparam int EW = (PW > POS_OUT_W) ? PW : POS_OUT_W;
    localparam logic [PW:0] MAXV = (PW+1)'(MAX_PAYLOAD);

    logic [3:0]    r_phase, n_phase;
    logic          r_upper, n_upper;
    logic [7:0]    r_acc, n_acc;
    logic [31:0]   r_addr, n_addr;
    logic [15:0]   r_port, n_port;
    logic [PW-1:0] r_pos, n_pos;
    logic [PW-1:0] r_start, n_start;
    logic          r_found, n_found;

    logic          hit;
    logic          hunt;
    logic [PW:0]   pos_inc;
    logic [PW-1:0] pos_nx;
    logic [PW:0]   diff;
    logic [PW-1:0] len;
    logic [EW-1:0] len_ext;
    logic [EW-1:0] start_ext;
    logic [7:0]    b;

    assign b       = i_word.data_byte;
    assign pos_inc = {1'b0, r_pos} + {{PW{1'b0}}, 1'b1};
    assign pos_nx  = (pos_inc >= MAXV) ? '0 : pos_inc[PW-1:0];

    always_comb begin
        diff = {1'b0, r_pos} - {1'b0, r_start};
        if (r_pos < r_start) begin
            diff = diff + MAXV;
        end
        len = diff[PW-1:0];
    end

    assign len_ext   = EW'(len);
    assign start_ext = EW'(r_start);

    always_comb begin
        n_phase = r_phase;
        n_upper = r_upper;
        n_acc   = r_acc;
        n_addr  = r_addr;
        n_port  = r_port;
        n_start = r_start;
        n_found = r_found;
        hit     = 1'b0;
        hunt    = 1'b0;
        if (!r_found) begin
            if (r_phase inside {[PH_KW1:PH_KW4]}) begin
                if (b == kw_char(r_phase, r_upper)) begin
                    n_phase = r_phase + 4'd1;
                    if (r_phase == PH_KW4) begin
                        n_start = pos_nx;
                        n_acc   = '0;
                        n_addr  = '0;
                        n_port  = '0;
                    end
                end else begin
                    hunt = 1'b1;
                end
            end else if (r_phase inside {[PH_NUM0:PH_NUM5]}) begin
                if (b inside {[CH_ZERO:CH_NINE]}) begin
                    n_acc = {r_acc[4:0], 3'b000} + {r_acc[6:0], 1'b0} + (b - CH_ZERO);
                end else if (r_phase != PH_NUM5 && b == CH_COMMA) begin
                    if (r_phase == PH_NUM4) begin
                        n_port = {r_port[7:0], r_acc};
                    end else begin
                        n_addr = {r_addr[23:0], r_acc};
                    end
                    n_acc   = '0;
                    n_phase = r_phase + 4'd1;
                end else if (r_phase == PH_NUM5 && (b == CH_CR || b == CH_LF)) begin
                    hit     = i_step;
                    n_found = 1'b1;
                    n_phase = PH_HUNT;
                end else begin
                    hunt = 1'b1;
                end
            end else begin
                hunt = 1'b1;
            end
            if (hunt) begin
                n_phase = PH_HUNT;
                if (i_word.may_start && (b == CH_P_UP || b == CH_P_LO)) begin
                    n_phase = PH_KW1;
                    n_upper = (b == CH_P_UP);
                end
            end
        end
        n_pos = pos_nx;
        if (i_word.last) begin
            n_phase = PH_HUNT;
            n_upper = 1'b0;
            n_acc   = '0;
            n_addr  = '0;
            n_port  = '0;
            n_pos   = '0;
            n_start = '0;
            n_found = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
            r_pos   <= '0;
            r_found <= 1'b0;
            r_upper <= 1'b0;
            r_acc   <= '0;
            r_addr  <= '0;
            r_port  <= '0;
            r_start <= '0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_found <= n_found;
            r_upper <= n_upper;
            r_acc   <= n_acc;
            r_addr  <= n_addr;
            r_port  <= n_port;
            r_start <= n_start;
        end
    end

    assign o_res.client_addr = r_addr;
    assign o_res.client_port = {r_port[7:0], r_acc};
    assign o_res.arg_offset  = start_ext[POS_OUT_W-1:0];
    assign o_res.arg_length  = len_ext[POS_OUT_W-1:0];
    assign o_stat.hit        = hit;
    assign o_stat.found      = r_found;

endmodule

// File: hdl/ftp_port_command_parser.sv
// FTP PORT command parser.
// Input channel: one payload byte per word (i_in_data: data_byte, may_start,
// last) on i_in_valid, held off by o_in_stall. Output channel: one result
// word (address, port, argument offset and length) on o_out_valid, held by
// i_out_stall.
// A byte is registered on acceptance and scanned from the input register; a
// result is registered to o_out_valid when the scan step takes the
// terminating CR or LF. One byte is accepted every cycle while o_in_stall is
// low; the rate is set by the scan step between the input and result
// registers. At most one result per packet; state clears after the byte
// flagged last.
// Reset (synchronous, active low) empties both registers and returns the
// scanner to keyword hunting at payload offset zero.
// While the receiver stalls a pending result, the scan step halts and
// o_in_stall rises once the input register is full; bytes that give no
// result still pass while the result register is empty.
module ftp_port_command_parser
    import ftppcp_pkg::*;
#(
    parameter int MAX_PAYLOAD = DEF_MAX_PAYLOAD
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  t_in_word  i_in_data,
    output logic      o_in_stall,
    output logic      o_out_valid,
    output t_out_word o_out_data,
    input  logic      i_out_stall
);

    logic       r_in_valid;
    t_in_word   r_in;
    logic       r_out_valid;
    t_out_word  r_out;
    logic       proc_ok;
    logic       step;
    t_out_word  scan_res;
    t_scan_stat scan_stat;

    assign proc_ok    = !r_out_valid || !i_out_stall;
    assign step       = r_in_valid && proc_ok;
    assign o_in_stall = r_in_valid && !proc_ok;

    ftppcp_scan #(
        .MAX_PAYLOAD(MAX_PAYLOAD)
    ) u_scan (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_step (step),
        .i_word (r_in),
        .o_res  (scan_res),
        .o_stat (scan_stat)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (proc_ok) begin
                r_out_valid <= scan_stat.hit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in <= i_in_data;
        end
        if (scan_stat.hit) begin
            r_out <= scan_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_out_valid && i_out_stall))
        else $error("input stalled without output backpressure");

    a_hit_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        scan_stat.hit |-> (!scan_stat.found && step))
        else $error("second match reported in one packet");

    a_hit_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        scan_stat.hit |=> o_out_valid)
        else $error("match not presented on output");

    a_found_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (scan_stat.found && !(step && r_in.last)) |=> scan_stat.found)
        else $error("match flag dropped before last byte");

endmodule

// File: tb/sv/ftp_port_command_parser_tb.sv
`timescale 1ns / 100ps

module ftp_port_command_parser_tb;
    import ftppcp_pkg::*;

    localparam int CLK_HALF       = 4;
    localparam int CYCLE_LIMIT    = 600000;
    localparam int RESULT_LATENCY = 4;
    localparam int HOLD_CYCLES    = 300;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    t_in_word  i_in_data;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_word o_out_data;
    logic      i_out_stall;

    logic [3:0]  scan_phase;
    logic        kw_is_upper;
    logic [7:0]  num_acc;
    logic [31:0] addr_acc;
    logic [15:0] port_acc;
    logic [10:0] byte_pos;
    logic [10:0] arg_begin;
    logic        cmd_found;

    t_out_word pending_port_cmds[$];

    int errors        = 0;
    int bytes_sent    = 0;
    int results_seen  = 0;
    int cycle_count   = 0;
    bit tx_idle_en    = 1'b0;
    bit rx_idle_en    = 1'b0;
    bit hold_request  = 1'b0;

    ftp_port_command_parser u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    function automatic logic [7:0] keyword_byte(input int idx, input logic up);
        logic [7:0] c;
        case (idx)
            0:       c = CH_P_LO;
            1:       c = 8'h6F;
            2:       c = 8'h72;
            3:       c = 8'h74;
            default: c = CH_SPACE;
        endcase
        if (up && c != CH_SPACE) begin
            c = c & 8'hDF;
        end
        return c;
    endfunction

    task automatic clear_scan_state();
        scan_phase  = PH_HUNT;
        kw_is_upper = 1'b0;
        num_acc     = '0;
        addr_acc    = '0;
        port_acc    = '0;
        byte_pos    = '0;
        arg_begin   = '0;
        cmd_found   = 1'b0;
    endtask

    // byte_pos and arg_begin wrap at 2048 through their 11-bit width
    task automatic track_port_scan(input t_in_word w);
        logic [7:0] b;
        logic       rehunt;
        t_out_word  r;
        b      = w.data_byte;
        rehunt = 1'b0;
        if (!cmd_found) begin
            if (scan_phase >= PH_KW1 && scan_phase <= PH_KW4) begin
                if (b == keyword_byte(int'(scan_phase), kw_is_upper)) begin
                    scan_phase = scan_phase + 4'd1;
                    if (scan_phase == PH_NUM0) begin
                        arg_begin = byte_pos + 11'd1;
                        num_acc   = '0;
                        addr_acc  = '0;
                        port_acc  = '0;
                    end
                end else begin
                    scan_phase = PH_HUNT;
                    rehunt     = 1'b1;
                end
            end else if (scan_phase >= PH_NUM0 && scan_phase <= PH_NUM5) begin
                if (b >= CH_ZERO && b <= CH_NINE) begin
                    num_acc = num_acc * 8'd10 + (b - CH_ZERO);
                end else if (scan_phase != PH_NUM5 && b == CH_COMMA) begin
                    if (scan_phase <= PH_NUM3) begin
                        addr_acc = {addr_acc[23:0], num_acc};
                    end else begin
                        port_acc = {port_acc[7:0], num_acc};
                    end
                    num_acc    = '0;
                    scan_phase = scan_phase + 4'd1;
                end else if (scan_phase == PH_NUM5 && (b == CH_CR || b == CH_LF)) begin
                    r.client_addr = addr_acc;
                    r.client_port = {port_acc[7:0], num_acc};
                    r.arg_offset  = arg_begin;
                    r.arg_length  = byte_pos - arg_begin;
                    pending_port_cmds.push_back(r);
                    cmd_found  = 1'b1;
                    scan_phase = PH_HUNT;
                end else begin
                    scan_phase = PH_HUNT;
                    rehunt     = 1'b1;
                end
            end else begin
                scan_phase = PH_HUNT;
                rehunt     = 1'b1;
            end
            if (rehunt && w.may_start && (b == CH_P_UP || b == CH_P_LO)) begin
                scan_phase  = PH_KW1;
                kw_is_upper = (b == CH_P_UP);
            end
        end
        byte_pos = byte_pos + 11'd1;
        if (w.last) begin
            clear_scan_state();
        end
    endtask

    task automatic send_word(input logic [7:0] b, input logic may, input logic lst);
        t_in_word w;
        w.data_byte = b;
        w.may_start = may;
        w.last      = lst;
        if (tx_idle_en && $urandom_range(0, 6) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= w;
        do @(posedge i_clk); while (o_in_stall);
        track_port_scan(w);
        bytes_sent++;
    endtask

    task automatic send_text(input string s, input logic may, input logic end_pkt);
        for (int i = 0; i < s.len(); i++) begin
            send_word(s[i], may, end_pkt && (i == s.len() - 1));
        end
    endtask

    function automatic string random_port_cmd();
        return $sformatf("%s %0d,%0d,%0d,%0d,%0d,%0d%s",
            $urandom_range(0, 1) ? "PORT" : "port",
            $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255),
            $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 999),
            $urandom_range(0, 1) ? "\r" : "\n");
    endfunction

    function automatic logic [7:0] noise_byte();
        case ($urandom_range(0, 7))
            0:       return CH_P_UP;
            1:       return CH_P_LO;
            2:       return CH_COMMA;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_random_packet(input int max_noise);
        logic [7:0] pkt[$];
        int         n_cmds;
        int         cmd_start;
        int         digits;
        int         keep;
        logic       up;
        n_cmds = ($urandom_range(0, 9) < 8) ? 1 : ($urandom_range(0, 1) ? 2 : 0);
        for (int c = 0; c < n_cmds; c++) begin
            repeat ($urandom_range(0, max_noise)) pkt.push_back(noise_byte());
            cmd_start = pkt.size();
            up        = 1'($urandom_range(0, 1));
            for (int k = 0; k < 5; k++) begin
                pkt.push_back(keyword_byte(k, up));
            end
            for (int n = 0; n < 6; n++) begin
                digits = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 6)
                                                     : $urandom_range(0, 3);
                repeat (digits) pkt.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
                if (n < 5) begin
                    pkt.push_back(CH_COMMA);
                end
            end
            pkt.push_back($urandom_range(0, 1) ? CH_CR : CH_LF);
            case ($urandom_range(0, 11))
                0: pkt[cmd_start + $urandom_range(1, 3)] ^= CH_SPACE;
                1: pkt[$urandom_range(cmd_start, pkt.size() - 1)] = 8'($urandom_range(0, 255));
                default: ;
            endcase
        end
        repeat ($urandom_range(0, max_noise)) pkt.push_back(noise_byte());
        if (pkt.size() == 0) begin
            pkt.push_back(noise_byte());
        end
        if ($urandom_range(0, 9) == 0) begin
            keep = $urandom_range(1, pkt.size());
            while (pkt.size() > keep) pkt.pop_back();
        end
        for (int i = 0; i < pkt.size(); i++) begin
            send_word(pkt[i], $urandom_range(0, 9) != 0, i == pkt.size() - 1);
        end
    endtask

    task automatic wait_for_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_port_cmds.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_directed_commands();
        send_text("PPORT 9,,,,,\r", 1'b1, 1'b1);
        send_text("port 255,999,,,1,300\n", 1'b1, 1'b1);
        send_word(CH_P_UP, 1'b0, 1'b0);
        send_text("ORT ,,,,,\n", 1'b1, 1'b1);
        send_word(8'hFF, 1'b1, 1'b0);
        send_word(8'h00, 1'b0, 1'b1);
    endtask

    task automatic test_random_packets();
        int byte_goal;
        int result_goal;
        byte_goal   = bytes_sent + 300;
        result_goal = results_seen + 10;
        while (bytes_sent < byte_goal || results_seen < result_goal) begin
            send_random_packet(4);
        end
    endtask

    task automatic test_receiver_hold();
        bit saved_idle;
        saved_idle   = tx_idle_en;
        tx_idle_en   = 1'b0;
        hold_request = 1'b1;
        repeat (6) send_text(random_port_cmd(), 1'b1, 1'b1);
        tx_idle_en = saved_idle;
        wait_for_results();
    endtask

    task automatic test_sender_pause();
        repeat (4) begin
            send_random_packet(3);
            wait_for_results();
        end
    endtask

    task automatic test_payload_wrap();
        repeat (2030 + $urandom_range(0, 15)) send_word(8'($urandom_range(0, 255)), 1'b0, 1'b0);
        send_text(random_port_cmd(), 1'b1, 1'b1);
    endtask

    task automatic test_steady_stream();
        repeat (8) send_random_packet(2);
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    task automatic check_port_result(input t_out_word got);
        t_out_word want;
        if (pending_port_cmds.size() == 0) begin
            errors++;
            $display("%0t: unexpected word, expected none, actual addr %0h port %0h",
                     $time, got.client_addr, got.client_port);
        end else begin
            want = pending_port_cmds.pop_front();
            results_seen++;
            compare_field("client_addr", want.client_addr, got.client_addr);
            compare_field("client_port", 32'(want.client_port), 32'(got.client_port));
            compare_field("arg_offset", 32'(want.arg_offset), 32'(got.arg_offset));
            compare_field("arg_length", 32'(want.arg_length), 32'(got.arg_length));
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            check_port_result(o_out_data);
        end
    end

    initial begin
        int stall_left;
        stall_left = 0;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_left > 0) begin
                i_out_stall <= 1'b1;
                stall_left--;
            end else begin
                i_out_stall <= 1'b0;
                if (hold_request) begin
                    hold_request = 1'b0;
                    stall_left   = HOLD_CYCLES;
                end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
                    stall_left = $urandom_range(1, 13);
                end
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("%0t: cycle limit reached, %0d results still due", $time,
                 pending_port_cmds.size());
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_data  <= '0;
        clear_scan_state();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_commands();
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        test_random_packets();
        test_receiver_hold();
        test_sender_pause();
        test_payload_wrap();
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        test_steady_stream();

        wait_for_results();
        repeat (RESULT_LATENCY * 2) @(posedge i_clk);

        $display("Scanned %0d payload bytes and checked %0d PORT results,", bytes_sent,
                 results_seen);
        $display("with offset wrap, long output hold, drain pauses and gap-free streaming.");
        if (errors == 0 && pending_port_cmds.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// File: ftp_port_command_parser.f
hdl/ftppcp_pkg.sv
hdl/ftppcp_scan.sv
hdl/ftp_port_command_parser.sv
tb/sv/ftp_port_command_parser_tb.sv
